// ----- hw/rtl/paet_pkg.sv -----
// paet_pkg: shared types and constants of the pixel alpha envelope tracker
// record layouts for the per-pixel running and best memories, phase codes
// no dependencies
`default_nettype none

package paet_pkg;

    // geometry
    localparam int unsigned PIXELS  = 4096;
    localparam int unsigned PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned AREA_W  = 24;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL = 1'b1;

    // reset values of the configuration registers
    localparam logic [ALPHA_W-1:0] START_LEVEL_RST = 8'd4;
    localparam logic [ALPHA_W-1:0] NOISE_LEVEL_RST = 8'd32;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [FRAME_W-1:0] atk_start;
        logic [FRAME_W-1:0] atk_end;
        logic [FRAME_W-1:0] rel_start;
        logic [FRAME_W-1:0] rel_end;
    } t_times;

    // running record of one pixel
    typedef struct packed {
        t_phase             phase;
        t_times             times;
        logic [ALPHA_W-1:0] peak;
        logic [ALPHA_W-1:0] rel_min;
        logic [AREA_W-1:0]  area;
    } t_run;

    // best envelope of one pixel
    typedef struct packed {
        logic              flag;
        t_times            times;
        logic [AREA_W-1:0] area;
    } t_best;

    typedef struct packed {
        logic [ALPHA_W-1:0] start_level;
        logic [ALPHA_W-1:0] noise_level;
    } t_cfg;

    localparam int unsigned RUN_W  = $bits(t_run);
    localparam int unsigned BEST_W = $bits(t_best);

endpackage

`default_nettype wire

// ----- hw/rtl/paet_ram.sv -----
// paet_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies
`default_nettype none

module paet_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/paet_update.sv -----
// paet_update: one envelope step of a pixel, running record and best record
// in, updated records and completion flag out; uses paet_pkg
`default_nettype none

module paet_update
    import paet_pkg::*;
(
    input  wire t_cfg                     i_cfg,
    input  wire t_run                     i_run,
    input  wire t_best                    i_best,
    input  wire logic [ALPHA_W-1:0]       i_alpha,
    input  wire logic [FRAME_W-1:0]       i_frame,
    output t_run                          o_run,
    output t_best                         o_best,
    output logic                          o_completed
);

    always_comb begin
        t_run            run;
        t_best           best;
        logic            closed;
        logic            sus;
        logic            done;
        logic [AREA_W:0] sum;

        run    = i_run;
        best   = i_best;
        closed = 1'b0;
        sus    = 1'b0;
        done   = 1'b0;

        // phase step, sustain evaluation shared below
        case (i_run.phase)
            PH_IDLE: begin
                if (i_alpha > i_cfg.start_level) begin
                    run.phase           = PH_ATTACK;
                    run.times.atk_start = i_frame;
                    run.peak            = i_alpha;
                end
            end
            PH_ATTACK: begin
                if (i_alpha > i_run.peak) begin
                    run.peak          = i_alpha;
                    run.times.atk_end = i_frame;
                end else begin
                    sus = 1'b1;
                end
            end
            PH_SUSTAIN: begin
                sus = 1'b1;
            end
            PH_RELEASE: begin
                if (i_alpha <= i_run.rel_min) begin
                    if (i_alpha > i_cfg.noise_level) begin
                        run.rel_min       = i_alpha;
                        run.times.rel_end = i_frame;
                    end else if (i_alpha < i_cfg.noise_level) begin
                        run.phase         = PH_IDLE;
                        run.times.rel_end = i_frame;
                        run.rel_min       = '0;
                        closed            = 1'b1;
                    end
                end else begin
                    sus = 1'b1;
                end
            end
            default: begin
                run = i_run;
            end
        endcase

        // sustain evaluation
        if (sus) begin
            run.phase = PH_SUSTAIN;
            if (i_alpha > i_run.peak) begin
                run.peak          = i_alpha;
                run.times.atk_end = i_frame;
                run.phase         = PH_ATTACK;
            end else if (i_alpha < i_run.peak) begin
                run.times.rel_start = i_frame;
                run.times.rel_end   = i_frame;
                run.rel_min         = i_alpha;
                run.phase           = PH_RELEASE;
                if (i_alpha == '0) begin
                    run.phase   = PH_IDLE;
                    run.rel_min = '0;
                    closed      = 1'b1;
                end
            end
        end

        // completion of a valid envelope, best kept by strictly larger area
        if (closed && (run.peak > i_cfg.noise_level)) begin
            done = 1'b1;
            if (run.times.atk_end < run.times.atk_start) begin
                run.times.atk_end = run.times.atk_start;
            end
            if (!i_best.flag || (run.area > i_best.area)) begin
                best.flag  = 1'b1;
                best.times = run.times;
                best.area  = run.area;
            end
            run = '0;
        end

        // saturating area while active
        sum = {1'b0, run.area} + {{(AREA_W + 1 - ALPHA_W){1'b0}}, i_alpha};
        if (run.phase != PH_IDLE) begin
            run.area = sum[AREA_W] ? AREA_MAX : sum[AREA_W-1:0];
        end

        o_run       = run;
        o_best      = best;
        o_completed = done;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_alpha_envelope_tracker_unit.sv -----
// pixel_alpha_envelope_tracker_unit: an input transaction is registered in the read stage
// as its pixel record is read, its result in the output register; one transaction per cycle
// while the output is not stalled: read of the pixel record, update and write-back overlap,
// with forwarding of the last written record for back-to-back same-pixel hits; reset: config
// registers return to their defaults, then a clearing pass writes zero to all PIXELS entries
// of both memories, input ready stays low meanwhile; uses paet_pkg, paet_ram, paet_update
`default_nettype none

module pixel_alpha_envelope_tracker_unit
    import paet_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ALPHA_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [IDX_W-1:0]     i_pixel_index,
    input  wire logic [ALPHA_W-1:0]   i_alpha,
    input  wire logic [FRAME_W-1:0]   i_frame_number,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_completed,
    output logic [1:0]                o_phase_now,
    output logic                      o_best_valid,
    output logic [FRAME_W-1:0]        o_best_attack_start,
    output logic [FRAME_W-1:0]        o_best_attack_end,
    output logic [FRAME_W-1:0]        o_best_release_start,
    output logic [FRAME_W-1:0]        o_best_release_end,
    output logic [AREA_W-1:0]         o_best_area
);

    // configuration registers
    t_cfg r_cfg;

    // clearing pass
    logic             r_clearing;
    logic [PIX_W-1:0] r_clr_addr;

    // read stage
    logic               r_s1_valid;
    logic               r_s1_inr;
    logic [PIX_W-1:0]   r_s1_addr;
    logic [ALPHA_W-1:0] r_s1_alpha;
    logic [FRAME_W-1:0] r_s1_frame;

    // last written record, for forwarding
    logic             r_wb_valid;
    logic [PIX_W-1:0] r_wb_addr;
    t_run             r_wb_run;
    t_best            r_wb_best;

    // output register
    logic   r_out_valid;
    logic   r_out_completed;
    t_phase r_out_phase;
    t_best  r_out_best;

    logic             in_acc;
    logic             in_range;
    logic             s1_adv;
    logic             fwd;
    logic [RUN_W-1:0] ram_run_rdata;
    logic [BEST_W-1:0] ram_best_rdata;
    t_run             cur_run;
    t_best            cur_best;
    t_run             upd_run;
    t_best            upd_best;
    logic             upd_completed;
    logic             we;
    logic [PIX_W-1:0] waddr;
    logic [RUN_W-1:0] wdata_run;
    logic [BEST_W-1:0] wdata_best;

    // handshakes
    assign in_acc     = i_in_valid && o_in_ready;
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_range   = (32'(i_pixel_index) < 32'(PIXELS));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_level <= START_LEVEL_RST;
            r_cfg.noise_level <= NOISE_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_LEVEL: r_cfg.start_level <= i_cfg_data;
                CFG_NOISE_LEVEL: r_cfg.noise_level <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // clearing pass over both memories after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == PIX_W'(PIXELS - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + PIX_W'(1);
            end
        end
    end

    // read stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_inr   <= in_range;
            r_s1_addr  <= i_pixel_index[PIX_W-1:0];
            r_s1_alpha <= i_alpha;
            r_s1_frame <= i_frame_number;
        end
    end

    // record memories
    paet_ram #(
        .WIDTH (RUN_W),
        .DEPTH (PIXELS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_run),
        .i_re    (in_acc),
        .i_raddr (i_pixel_index[PIX_W-1:0]),
        .o_rdata (ram_run_rdata)
    );

    paet_ram #(
        .WIDTH (BEST_W),
        .DEPTH (PIXELS)
    ) u_best_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_best),
        .i_re    (in_acc),
        .i_raddr (i_pixel_index[PIX_W-1:0]),
        .o_rdata (ram_best_rdata)
    );

    // forward the record written at the same edge as this read
    assign fwd      = r_wb_valid && (r_wb_addr == r_s1_addr);
    assign cur_run  = fwd ? r_wb_run  : t_run'(ram_run_rdata);
    assign cur_best = fwd ? r_wb_best : t_best'(ram_best_rdata);

    paet_update u_update (
        .i_cfg       (r_cfg),
        .i_run       (cur_run),
        .i_best      (cur_best),
        .i_alpha     (r_s1_alpha),
        .i_frame     (r_s1_frame),
        .o_run       (upd_run),
        .o_best      (upd_best),
        .o_completed (upd_completed)
    );

    // write-back, or zero fill while clearing
    always_comb begin
        if (r_clearing) begin
            we         = 1'b1;
            waddr      = r_clr_addr;
            wdata_run  = '0;
            wdata_best = '0;
        end else begin
            we         = s1_adv && r_s1_inr;
            waddr      = r_s1_addr;
            wdata_run  = upd_run;
            wdata_best = upd_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (s1_adv) begin
            r_wb_valid <= r_s1_inr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_inr) begin
            r_wb_addr <= r_s1_addr;
            r_wb_run  <= upd_run;
            r_wb_best <= upd_best;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (r_s1_inr) begin
                r_out_completed <= upd_completed;
                r_out_phase     <= upd_run.phase;
                r_out_best      <= upd_best;
            end else begin
                r_out_completed <= 1'b0;
                r_out_phase     <= PH_IDLE;
                r_out_best      <= '0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_completed          = r_out_completed;
    assign o_phase_now          = r_out_phase;
    assign o_best_valid         = r_out_best.flag;
    assign o_best_attack_start  = r_out_best.times.atk_start;
    assign o_best_attack_end    = r_out_best.times.atk_end;
    assign o_best_release_start = r_out_best.times.rel_start;
    assign o_best_release_end   = r_out_best.times.rel_end;
    assign o_best_area          = r_out_best.area;

endmodule

`default_nettype wire
